[design/assert_macros.svh]
// Assertion helpers for the design files; the top-level module uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked only out of reset.
`define NSQG_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nsqg assertion failed");
// Checked on every edge, reset included.
`define NSQG_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nsqg assertion failed");
`else
`define NSQG_ASSERT(lbl, prop)
`define NSQG_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

[design/nsqg_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsqg_pkg
// Types, constants and helpers shared by the nine-slice quad generator.
// ----------------------------------------------------------------------------
package nsqg_pkg;

  localparam int ATLAS_SIZE_DEF = 2048;
  localparam int FIFO_DEPTH_DEF = 2;
  localparam int NUM_W          = 27;
  localparam int UV_W           = 17;
  localparam logic [UV_W-1:0] UV_MAX = 17'h1FFFF;
  localparam int DIV_STEPS      = 17;
  localparam int NPIECE         = 9;

  typedef enum logic [3:0] {
    PIECE_CENTER = 4'd0,
    PIECE_LEFT   = 4'd1,
    PIECE_TOP    = 4'd2,
    PIECE_RIGHT  = 4'd3,
    PIECE_BOTTOM = 4'd4,
    PIECE_TL     = 4'd5,
    PIECE_BR     = 4'd6,
    PIECE_BL     = 4'd7,
    PIECE_TR     = 4'd8
  } nsqg_piece_t;

  typedef enum logic [1:0] {
    REG_LEFT   = 2'd0,
    REG_TOP    = 2'd1,
    REG_RIGHT  = 2'd2,
    REG_BOTTOM = 2'd3
  } nsqg_reg_t;

  // Which band of one axis a piece covers.
  typedef enum logic [1:0] {
    BAND_LO  = 2'd0,
    BAND_MID = 2'd1,
    BAND_HI  = 2'd2
  } nsqg_band_t;

  typedef struct packed {
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic signed [23:0] size_w;
    logic signed [23:0] size_h;
    logic [15:0]        scale;
    logic [10:0]        atlas_x;
    logic [10:0]        atlas_y;
    logic [11:0]        atlas_w;
    logic [11:0]        atlas_h;
    logic               flipped;
  } nsqg_in_t;

  typedef struct packed {
    logic [3:0]         piece;
    logic signed [23:0] quad_x;
    logic signed [23:0] quad_y;
    logic signed [23:0] quad_w;
    logic signed [23:0] quad_h;
    logic [UV_W-1:0]    uv_left;
    logic [UV_W-1:0]    uv_top;
    logic [UV_W-1:0]    uv_right;
    logic [UV_W-1:0]    uv_bottom;
    logic               flip_out;
    logic               last;
  } nsqg_out_t;

  // Geometry of one widget, everything but the inner UVs.
  typedef struct packed {
    logic [23:0]     ox;
    logic [23:0]     oy;
    logic [23:0]     ix;
    logic [23:0]     iy;
    logic [23:0]     ex;
    logic [23:0]     ey;
    logic [23:0]     lw;
    logic [23:0]     th;
    logic [23:0]     rw;
    logic [23:0]     bh;
    logic [23:0]     iw;
    logic [23:0]     ih;
    logic [UV_W-1:0] uv_ol;
    logic [UV_W-1:0] uv_or;
    logic [UV_W-1:0] uv_ot;
    logic [UV_W-1:0] uv_ob;
    logic            nx0;
    logic            ny0;
    logic            flip;
    logic [3:0]      brd;   // nonzero borders: bit 0 left, 1 top, 2 right, 3 bottom
  } nsqg_geom_t;

  typedef struct packed {
    nsqg_geom_t      g;
    logic [UV_W-1:0] uv_l;
    logic [UV_W-1:0] uv_r;
    logic [UV_W-1:0] uv_t;
    logic [UV_W-1:0] uv_b;
  } nsqg_job_t;

  function automatic nsqg_band_t col_of(input nsqg_piece_t p);
    nsqg_band_t b;
    unique case (p)
      PIECE_LEFT, PIECE_TL, PIECE_BL:  b = BAND_LO;
      PIECE_RIGHT, PIECE_BR, PIECE_TR: b = BAND_HI;
      default:                         b = BAND_MID;
    endcase
    return b;
  endfunction

  function automatic nsqg_band_t row_of(input nsqg_piece_t p);
    nsqg_band_t b;
    unique case (p)
      PIECE_TOP, PIECE_TL, PIECE_TR:    b = BAND_LO;
      PIECE_BOTTOM, PIECE_BR, PIECE_BL: b = BAND_HI;
      default:                          b = BAND_MID;
    endcase
    return b;
  endfunction

endpackage

[design/nine_slice_quad_generator.sv]
`timescale 1ns / 1ps
// Each widget beat yields one to nine quads, one per cycle: a single quad
// with all borders zero, nine with all four set. The quad emitter sets that
// pace; the front stages and the 17-stage divider accept a new widget every
// cycle while the job queue has room, and busy rises only when the queue
// is full and the divider holds a finished job. With an empty queue the
// first quad of a widget passes the front stages, the divider, the job queue
// and the emitter's output register before it reaches the outputs. Quads
// cannot be stalled: each one is on out_data for exactly the cycle in which
// out_valid is high.
// ----------------------------------------------------------------------------
// nine_slice_quad_generator
// Nine-slice quad generator with programmable borders.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nine_slice_quad_generator #(
  parameter int ATLAS_SIZE = nsqg_pkg::ATLAS_SIZE_DEF,
  parameter int FIFO_DEPTH = nsqg_pkg::FIFO_DEPTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  nsqg_pkg::nsqg_in_t  in_data,
  output logic                out_valid,
  output nsqg_pkg::nsqg_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);

  localparam int XW = nsqg_pkg::NUM_W + 16 - $clog2(ATLAS_SIZE);

  logic [7:0] left_r, top_r, right_r, bottom_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r   <= '0;
      top_r    <= '0;
      right_r  <= '0;
      bottom_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (nsqg_pkg::nsqg_reg_t'(cfg_index))
        nsqg_pkg::REG_LEFT:   left_r   <= cfg_data;
        nsqg_pkg::REG_TOP:    top_r    <= cfg_data;
        nsqg_pkg::REG_RIGHT:  right_r  <= cfg_data;
        nsqg_pkg::REG_BOTTOM: bottom_r <= cfg_data;
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  logic                 adv, acc;
  logic                 f_vld;
  logic [XW-1:0]        f_x [4];
  logic [11:0]          f_n_x, f_n_y;
  logic [3:0]           f_pos, f_ovf;
  nsqg_pkg::nsqg_geom_t f_geom;

  logic                 div_vld;
  logic [nsqg_pkg::UV_W-1:0] div_q [4];
  nsqg_pkg::nsqg_geom_t div_geom;

  nsqg_pkg::nsqg_job_t  job, head;
  logic                 push, pop, head_vld, can_push;

  // The front stages and the divider hold only when a finished job has nowhere to go.
  assign adv  = !div_vld || can_push;
  assign busy = !adv;
  assign acc  = start && !busy;
  assign push = div_vld && adv;

  nsqg_front #(.ATLAS_SIZE(ATLAS_SIZE)) u_front (
    .clk, .rst_n, .adv, .acc, .in_data,
    .brd_l(left_r), .brd_t(top_r), .brd_r(right_r), .brd_b(bottom_r),
    .f_vld, .f_x, .f_n_x, .f_n_y, .f_pos, .f_ovf, .f_geom
  );

  nsqg_div #(.ATLAS_SIZE(ATLAS_SIZE)) u_div (
    .clk, .rst_n, .adv,
    .in_vld(f_vld), .in_x(f_x), .in_n_x(f_n_x), .in_n_y(f_n_y),
    .in_pos(f_pos), .in_ovf(f_ovf), .in_geom(f_geom),
    .out_vld(div_vld), .out_q(div_q), .out_geom(div_geom)
  );

  // An empty image rectangle has no border step: inner UVs equal outer UVs.
  always_comb begin
    job.g    = div_geom;
    job.uv_l = div_geom.nx0 ? div_geom.uv_ol : div_q[0];
    job.uv_r = div_geom.nx0 ? div_geom.uv_or : div_q[1];
    job.uv_t = div_geom.ny0 ? div_geom.uv_ot : div_q[2];
    job.uv_b = div_geom.ny0 ? div_geom.uv_ob : div_q[3];
  end

  nsqg_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo (
    .clk, .rst_n, .push, .wdata(job), .pop, .rdata(head),
    .not_empty(head_vld), .can_push
  );

  nsqg_emit u_emit (
    .clk, .rst_n, .head, .head_vld, .pop, .out_valid, .out_data
  );

  `NSQG_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid && !busy)
  `NSQG_ASSERT(a_busy_needs_job, busy |-> div_vld && head_vld)
  `NSQG_ASSERT(a_quad_run, out_valid && !out_data.last |=> out_valid)
  `NSQG_ASSERT(a_center_first, out_valid && $past(out_valid) && !$past(out_data.last) |-> out_data.piece != nsqg_pkg::PIECE_CENTER)

endmodule

[design/nsqg_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsqg_front
// Takes widget beats, forms border extents, positions and UV numerators.
// ----------------------------------------------------------------------------
module nsqg_front #(
  parameter int  ATLAS_SIZE = nsqg_pkg::ATLAS_SIZE_DEF,
  localparam int SHIFT      = 16 - $clog2(ATLAS_SIZE),
  localparam int XW         = nsqg_pkg::NUM_W + SHIFT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 adv,
  input  logic                 acc,
  input  nsqg_pkg::nsqg_in_t   in_data,
  input  logic [7:0]           brd_l,
  input  logic [7:0]           brd_t,
  input  logic [7:0]           brd_r,
  input  logic [7:0]           brd_b,
  output logic                 f_vld,
  output logic [XW-1:0]        f_x [4],
  output logic [11:0]          f_n_x,
  output logic [11:0]          f_n_y,
  output logic [3:0]           f_pos,
  output logic [3:0]           f_ovf,
  output nsqg_pkg::nsqg_geom_t f_geom
);

  localparam int NW = nsqg_pkg::NUM_W;
  localparam int OW = 14 + SHIFT;

  function automatic logic [nsqg_pkg::UV_W-1:0] uv_outer(input logic signed [13:0] num);
    logic [OW-1:0] w;
    w = OW'(num[12:0]) << SHIFT;
    if (num <= 14'sd0) return '0;
    if (w > OW'(nsqg_pkg::UV_MAX)) return nsqg_pkg::UV_MAX;
    return nsqg_pkg::UV_W'(w);
  endfunction

  // Stage 1: captured beat and borders.
  logic               s1_vld_r;
  nsqg_pkg::nsqg_in_t s1_in_r;
  logic [7:0]         s1_l_r, s1_t_r, s1_r_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (adv) begin
      s1_vld_r <= acc;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && acc) begin
      s1_in_r <= in_data;
      s1_l_r  <= brd_l;
      s1_t_r  <= brd_t;
      s1_r_r  <= brd_r;
      s1_b_r  <= brd_b;
    end
  end

  // Stage 2: products.
  logic                 s2_vld_r;
  nsqg_pkg::nsqg_in_t   s2_in_r;
  logic [3:0]           s2_brd_r;
  logic [23:0]          s2_lw_r, s2_th_r, s2_rw_r, s2_bh_r;
  logic [23:0]          s2_pa_x_r, s2_pa_y_r;
  logic signed [NW-1:0] s2_pe_x_r, s2_pe_y_r, s2_pl_x_r, s2_pl_y_r, s2_pr_x_r, s2_pr_y_r;

  logic [11:0]          ax1, ay1;
  logic signed [13:0]   aex, aey;
  logic signed [12:0]   nm2x, nm2y;

  always_comb begin
    ax1  = {1'b0, s1_in_r.atlas_x} + 12'd1;
    ay1  = {1'b0, s1_in_r.atlas_y} + 12'd1;
    aex  = $signed({3'b0, s1_in_r.atlas_x}) + $signed({2'b0, s1_in_r.atlas_w}) - 14'sd1;
    aey  = $signed({3'b0, s1_in_r.atlas_y}) + $signed({2'b0, s1_in_r.atlas_h}) - 14'sd1;
    nm2x = $signed({1'b0, s1_in_r.atlas_w}) - 13'sd2;
    nm2y = $signed({1'b0, s1_in_r.atlas_h}) - 13'sd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else if (adv) begin
      s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_in_r   <= s1_in_r;
      s2_brd_r  <= {|s1_b_r, |s1_r_r, |s1_t_r, |s1_l_r};
      s2_lw_r   <= 24'(s1_in_r.scale) * 24'(s1_l_r);
      s2_th_r   <= 24'(s1_in_r.scale) * 24'(s1_t_r);
      s2_rw_r   <= 24'(s1_in_r.scale) * 24'(s1_r_r);
      s2_bh_r   <= 24'(s1_in_r.scale) * 24'(s1_b_r);
      s2_pa_x_r <= 24'(ax1) * 24'(s1_in_r.atlas_w);
      s2_pa_y_r <= 24'(ay1) * 24'(s1_in_r.atlas_h);
      s2_pe_x_r <= NW'(aex) * NW'($signed({1'b0, s1_in_r.atlas_w}));
      s2_pe_y_r <= NW'(aey) * NW'($signed({1'b0, s1_in_r.atlas_h}));
      s2_pl_x_r <= NW'($signed({1'b0, s1_l_r})) * NW'(nm2x);
      s2_pr_x_r <= NW'($signed({1'b0, s1_r_r})) * NW'(nm2x);
      s2_pl_y_r <= NW'($signed({1'b0, s1_t_r})) * NW'(nm2y);
      s2_pr_y_r <= NW'($signed({1'b0, s1_b_r})) * NW'(nm2y);
    end
  end

  // Numerators of the inner UVs and their prescaled dividends.
  logic signed [NW-1:0] num [4];
  logic [11:0]          nl  [4];
  logic signed [13:0]   oex, oey;

  always_comb begin
    num[0] = NW'($signed({1'b0, s2_pa_x_r})) + s2_pl_x_r;
    num[1] = s2_pe_x_r - s2_pr_x_r;
    num[2] = NW'($signed({1'b0, s2_pa_y_r})) + s2_pl_y_r;
    num[3] = s2_pe_y_r - s2_pr_y_r;
    nl[0]  = s2_in_r.atlas_w;
    nl[1]  = s2_in_r.atlas_w;
    nl[2]  = s2_in_r.atlas_h;
    nl[3]  = s2_in_r.atlas_h;
    for (int j = 0; j < 4; j++) begin
      f_pos[j] = !num[j][NW-1] && (num[j] != '0);
      f_x[j]   = XW'(num[j][NW-2:0]) << SHIFT;
      // A quotient of 2.0 or more saturates without dividing.
      f_ovf[j] = f_x[j] >= (XW'(nl[j]) << nsqg_pkg::UV_W);
    end
    oex = $signed({3'b0, s2_in_r.atlas_x}) + $signed({2'b0, s2_in_r.atlas_w}) - 14'sd1;
    oey = $signed({3'b0, s2_in_r.atlas_y}) + $signed({2'b0, s2_in_r.atlas_h}) - 14'sd1;
  end

  always_comb begin
    f_geom.ox    = s2_in_r.pos_x;
    f_geom.oy    = s2_in_r.pos_y;
    f_geom.ix    = s2_in_r.pos_x + s2_lw_r;
    f_geom.iy    = s2_in_r.pos_y + s2_th_r;
    f_geom.ex    = s2_in_r.pos_x + s2_in_r.size_w - s2_rw_r;
    f_geom.ey    = s2_in_r.pos_y + s2_in_r.size_h - s2_bh_r;
    f_geom.lw    = s2_lw_r;
    f_geom.th    = s2_th_r;
    f_geom.rw    = s2_rw_r;
    f_geom.bh    = s2_bh_r;
    f_geom.iw    = s2_in_r.size_w - s2_lw_r - s2_rw_r;
    f_geom.ih    = s2_in_r.size_h - s2_th_r - s2_bh_r;
    f_geom.uv_ol = uv_outer($signed({3'b0, s2_in_r.atlas_x}) + 14'sd1);
    f_geom.uv_or = uv_outer(oex);
    f_geom.uv_ot = uv_outer($signed({3'b0, s2_in_r.atlas_y}) + 14'sd1);
    f_geom.uv_ob = uv_outer(oey);
    f_geom.nx0   = (s2_in_r.atlas_w == 12'd0);
    f_geom.ny0   = (s2_in_r.atlas_h == 12'd0);
    f_geom.flip  = s2_in_r.flipped;
    f_geom.brd   = s2_brd_r;
  end

  assign f_vld = s2_vld_r;
  assign f_n_x = s2_in_r.atlas_w;
  assign f_n_y = s2_in_r.atlas_h;

endmodule

[design/nsqg_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsqg_div
// Four-lane restoring divider, one quotient bit per pipeline stage.
// ----------------------------------------------------------------------------
module nsqg_div #(
  parameter int  ATLAS_SIZE = nsqg_pkg::ATLAS_SIZE_DEF,
  localparam int SHIFT      = 16 - $clog2(ATLAS_SIZE),
  localparam int XW         = nsqg_pkg::NUM_W + SHIFT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         adv,
  input  logic                         in_vld,
  input  logic [XW-1:0]                in_x [4],
  input  logic [11:0]                  in_n_x,
  input  logic [11:0]                  in_n_y,
  input  logic [3:0]                   in_pos,
  input  logic [3:0]                   in_ovf,
  input  nsqg_pkg::nsqg_geom_t         in_geom,
  output logic                         out_vld,
  output logic [nsqg_pkg::UV_W-1:0]    out_q [4],
  output nsqg_pkg::nsqg_geom_t         out_geom
);

  localparam int NS = nsqg_pkg::DIV_STEPS;
  localparam int QW = nsqg_pkg::UV_W;

  logic                 vld_r  [NS];
  logic [XW-1:0]        rem_r  [NS][4];
  logic [QW-1:0]        q_r    [NS][4];
  logic [11:0]          nx_r   [NS];
  logic [11:0]          ny_r   [NS];
  logic [3:0]           pos_r  [NS];
  logic [3:0]           ovf_r  [NS];
  nsqg_pkg::nsqg_geom_t geom_r [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;

    logic                 st_vld;
    logic [XW-1:0]        st_rem [4];
    logic [QW-1:0]        st_q   [4];
    logic [11:0]          st_nx, st_ny;
    logic [3:0]           st_pos, st_ovf;
    nsqg_pkg::nsqg_geom_t st_geom;
    logic [XW:0]          trial   [4];
    logic [XW-1:0]        rem_nxt [4];
    logic [QW-1:0]        q_nxt   [4];

    if (s == 0) begin : g_head
      assign st_vld  = in_vld;
      assign st_rem  = in_x;
      assign st_q    = '{default: '0};
      assign st_nx   = in_n_x;
      assign st_ny   = in_n_y;
      assign st_pos  = in_pos;
      assign st_ovf  = in_ovf;
      assign st_geom = in_geom;
    end else begin : g_body
      assign st_vld  = vld_r[s-1];
      assign st_rem  = rem_r[s-1];
      assign st_q    = q_r[s-1];
      assign st_nx   = nx_r[s-1];
      assign st_ny   = ny_r[s-1];
      assign st_pos  = pos_r[s-1];
      assign st_ovf  = ovf_r[s-1];
      assign st_geom = geom_r[s-1];
    end

    always_comb begin
      for (int j = 0; j < 4; j++) begin
        trial[j]   = {1'b0, st_rem[j]} - ((XW + 1)'(j < 2 ? st_nx : st_ny) << B);
        rem_nxt[j] = st_rem[j];
        q_nxt[j]   = st_q[j];
        if (!trial[j][XW]) begin
          rem_nxt[j]  = trial[j][XW-1:0];
          q_nxt[j][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (adv) begin
        vld_r[s] <= st_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[s]  <= rem_nxt;
        q_r[s]    <= q_nxt;
        nx_r[s]   <= st_nx;
        ny_r[s]   <= st_ny;
        pos_r[s]  <= st_pos;
        ovf_r[s]  <= st_ovf;
        geom_r[s] <= st_geom;
      end
    end
  end

  always_comb begin
    for (int j = 0; j < 4; j++) begin
      if (!pos_r[NS-1][j]) begin
        out_q[j] = '0;
      end else if (ovf_r[NS-1][j]) begin
        out_q[j] = nsqg_pkg::UV_MAX;
      end else begin
        out_q[j] = q_r[NS-1][j];
      end
    end
  end

  assign out_vld  = vld_r[NS-1];
  assign out_geom = geom_r[NS-1];

endmodule

[design/nsqg_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsqg_fifo
// Short job queue between the divider pipeline and the quad emitter.
// ----------------------------------------------------------------------------
module nsqg_fifo #(
  parameter int  DEPTH = nsqg_pkg::FIFO_DEPTH_DEF,
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int CW    = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  nsqg_pkg::nsqg_job_t wdata,
  input  logic                pop,
  output nsqg_pkg::nsqg_job_t rdata,
  output logic                not_empty,
  output logic                can_push
);

  nsqg_pkg::nsqg_job_t mem_r [DEPTH];
  logic [PW-1:0]       wp_r, rp_r;
  logic [CW-1:0]       cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= wdata;
    end
  end

  assign rdata     = mem_r[rp_r];
  assign not_empty = (cnt_r != '0);
  // A slot freed by this cycle's pop can be refilled at once.
  assign can_push  = (cnt_r != CW'(DEPTH)) || pop;

endmodule

[design/nsqg_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsqg_emit
// Walks the pieces of the head job and drives one quad per cycle.
// ----------------------------------------------------------------------------
module nsqg_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  nsqg_pkg::nsqg_job_t head,
  input  logic                head_vld,
  output logic                pop,
  output logic                out_valid,
  output nsqg_pkg::nsqg_out_t out_data
);

  localparam int NP = nsqg_pkg::NPIECE;

  logic [NP-1:0]         pend_r, pend_nxt;
  logic                  loaded_r, loaded_nxt;
  logic                  out_vld_r;
  nsqg_pkg::nsqg_out_t   out_r, out_nxt;

  logic [NP-1:0]         full, cur, sel, rest;
  logic [3:0]            idx;
  nsqg_pkg::nsqg_piece_t piece;
  logic [3:0]            b;

  always_comb begin
    b    = head.g.brd;
    // Center always, then edges, then corners, in emission order.
    full = {b[2] & b[1], b[0] & b[3], b[3] & b[2], b[1] & b[0],
            b[3], b[2], b[1], b[0], 1'b1};
    cur  = loaded_r ? pend_r : full;
    sel  = cur & (~cur + 1'b1);
    rest = cur & ~sel;
    idx  = '0;
    for (int i = 0; i < NP; i++) begin
      if (sel[i]) idx = 4'(i);
    end
    piece = nsqg_pkg::nsqg_piece_t'(idx);

    out_nxt          = out_r;
    out_nxt.piece    = piece;
    out_nxt.flip_out = head.g.flip;
    out_nxt.last     = (rest == '0);
    unique case (nsqg_pkg::col_of(piece))
      nsqg_pkg::BAND_LO: begin
        out_nxt.quad_x = head.g.ox;  out_nxt.quad_w = head.g.lw;
        out_nxt.uv_left = head.g.uv_ol;  out_nxt.uv_right = head.uv_l;
      end
      nsqg_pkg::BAND_HI: begin
        out_nxt.quad_x = head.g.ex;  out_nxt.quad_w = head.g.rw;
        out_nxt.uv_left = head.uv_r;  out_nxt.uv_right = head.g.uv_or;
      end
      default: begin
        out_nxt.quad_x = head.g.ix;  out_nxt.quad_w = head.g.iw;
        out_nxt.uv_left = head.uv_l;  out_nxt.uv_right = head.uv_r;
      end
    endcase
    unique case (nsqg_pkg::row_of(piece))
      nsqg_pkg::BAND_LO: begin
        out_nxt.quad_y = head.g.oy;  out_nxt.quad_h = head.g.th;
        out_nxt.uv_top = head.g.uv_ot;  out_nxt.uv_bottom = head.uv_t;
      end
      nsqg_pkg::BAND_HI: begin
        out_nxt.quad_y = head.g.ey;  out_nxt.quad_h = head.g.bh;
        out_nxt.uv_top = head.uv_b;  out_nxt.uv_bottom = head.g.uv_ob;
      end
      default: begin
        out_nxt.quad_y = head.g.iy;  out_nxt.quad_h = head.g.ih;
        out_nxt.uv_top = head.uv_t;  out_nxt.uv_bottom = head.uv_b;
      end
    endcase

    pop        = head_vld && (rest == '0);
    loaded_nxt = loaded_r;
    pend_nxt   = pend_r;
    if (head_vld) begin
      loaded_nxt = (rest != '0);
      pend_nxt   = rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      loaded_r  <= loaded_nxt;
      out_vld_r <= head_vld;
    end
  end

  always_ff @(posedge clk) begin
    pend_r <= pend_nxt;
    if (head_vld) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

endmodule

[sim/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives widget beats and border settings into the nine-slice quad generator
// and checks every quad against a predictor of the nine-slice geometry.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int  ATLAS        = 2048;
  localparam int  QUIET_LIMIT  = 20000;
  localparam int  DRAIN_CYCLES = 40;
  localparam int  RAND_ITEMS   = 300;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  nsqg_pkg::nsqg_in_t   in_data;
  logic                 out_valid;
  nsqg_pkg::nsqg_out_t  out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [7:0]           cfg_data;

  nsqg_pkg::nsqg_out_t  quad_queue[$];
  logic [7:0]           borders[4];
  int                   fail_count;
  int                   quiet_cycles;

  nine_slice_quad_generator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [nsqg_pkg::UV_W-1:0] uv_trunc(longint num, longint den);
    longint q;
    if (num <= 0) return '0;
    q = (num * 65536) / den;
    return (q > 131071) ? nsqg_pkg::UV_MAX : q[nsqg_pkg::UV_W-1:0];
  endfunction

  // Outer start, inner start, inner end, outer end along one axis.
  task automatic axis_uvs(input longint a, input longint n, input longint lo,
                          input longint hi, output logic [nsqg_pkg::UV_W-1:0] os,
                          output logic [nsqg_pkg::UV_W-1:0] is,
                          output logic [nsqg_pkg::UV_W-1:0] ie,
                          output logic [nsqg_pkg::UV_W-1:0] oe);
    os = uv_trunc(a + 1, ATLAS);
    oe = uv_trunc(a + n - 1, ATLAS);
    if (n == 0) begin
      is = os;
      ie = oe;
    end else begin
      is = uv_trunc((a + 1) * n + lo * (n - 2), longint'(ATLAS) * n);
      ie = uv_trunc((a + n - 1) * n - hi * (n - 2), longint'(ATLAS) * n);
    end
  endtask

  function automatic nsqg_pkg::nsqg_out_t make_quad(nsqg_pkg::nsqg_piece_t p,
                                                    longint x, longint y,
                                                    longint w, longint h,
                                                    logic [nsqg_pkg::UV_W-1:0] ul,
                                                    logic [nsqg_pkg::UV_W-1:0] ut,
                                                    logic [nsqg_pkg::UV_W-1:0] ur,
                                                    logic [nsqg_pkg::UV_W-1:0] ub,
                                                    logic fl);
    nsqg_pkg::nsqg_out_t q;
    q.piece = p;
    q.quad_x = x[23:0];
    q.quad_y = y[23:0];
    q.quad_w = w[23:0];
    q.quad_h = h[23:0];
    q.uv_left = ul;
    q.uv_top = ut;
    q.uv_right = ur;
    q.uv_bottom = ub;
    q.flip_out = fl;
    q.last = 1'b0;
    return q;
  endfunction

  task automatic predict_quads(input nsqg_pkg::nsqg_in_t w);
    longint ox, oy, sc, lb, tb, rb, bb, lw, th, rw, bh, ix, iy, iw, ih, ex, ey;
    logic [nsqg_pkg::UV_W-1:0] oul, ul, ur, our, out_t, ut, ub, oub;
    nsqg_pkg::nsqg_out_t q[$];
    ox = longint'(w.pos_x); oy = longint'(w.pos_y); sc = longint'(w.scale);
    lb = longint'(borders[nsqg_pkg::REG_LEFT]);
    tb = longint'(borders[nsqg_pkg::REG_TOP]);
    rb = longint'(borders[nsqg_pkg::REG_RIGHT]);
    bb = longint'(borders[nsqg_pkg::REG_BOTTOM]);
    lw = sc * lb; th = sc * tb; rw = sc * rb; bh = sc * bb;
    ix = ox + lw; iy = oy + th;
    iw = longint'(w.size_w) - lw - rw;
    ih = longint'(w.size_h) - th - bh;
    ex = ix + iw; ey = iy + ih;
    axis_uvs(longint'(w.atlas_x), longint'(w.atlas_w), lb, rb, oul, ul, ur, our);
    axis_uvs(longint'(w.atlas_y), longint'(w.atlas_h), tb, bb, out_t, ut, ub, oub);
    q.push_back(make_quad(nsqg_pkg::PIECE_CENTER, ix, iy, iw, ih, ul, ut, ur, ub,
                          w.flipped));
    if (lb > 0) q.push_back(make_quad(nsqg_pkg::PIECE_LEFT, ox, iy, lw, ih, oul, ut, ul,
                                      ub, w.flipped));
    if (tb > 0) q.push_back(make_quad(nsqg_pkg::PIECE_TOP, ix, oy, iw, th, ul, out_t, ur,
                                      ut, w.flipped));
    if (rb > 0) q.push_back(make_quad(nsqg_pkg::PIECE_RIGHT, ex, iy, rw, ih, ur, ut, our,
                                      ub, w.flipped));
    if (bb > 0) q.push_back(make_quad(nsqg_pkg::PIECE_BOTTOM, ix, ey, iw, bh, ul, ub, ur,
                                      oub, w.flipped));
    if (lb > 0 && tb > 0)
      q.push_back(make_quad(nsqg_pkg::PIECE_TL, ox, oy, lw, th, oul, out_t, ul, ut,
                            w.flipped));
    if (rb > 0 && bb > 0)
      q.push_back(make_quad(nsqg_pkg::PIECE_BR, ex, ey, rw, bh, ur, ub, our, oub,
                            w.flipped));
    if (lb > 0 && bb > 0)
      q.push_back(make_quad(nsqg_pkg::PIECE_BL, ox, ey, lw, bh, oul, ub, ul, oub,
                            w.flipped));
    if (rb > 0 && tb > 0)
      q.push_back(make_quad(nsqg_pkg::PIECE_TR, ex, oy, rw, th, ur, out_t, our, ut,
                            w.flipped));
    q[q.size()-1].last = 1'b1;
    foreach (q[i]) quad_queue.push_back(q[i]);
  endtask

  // Checker and watchdog.
  always @(posedge clk) begin
    nsqg_pkg::nsqg_out_t exp_q;
    if (rst_n) begin
      if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("FAIL");
        $finish;
      end
      if (out_valid) begin
        if (quad_queue.size() == 0) begin
          $display("%0t: unexpected quad, expected none, actual %h", $time, out_data);
          fail_count++;
        end else begin
          exp_q = quad_queue.pop_front();
          if (out_data !== exp_q) begin
            $display("%0t: quad mismatch, expected %h, actual %h", $time, exp_q, out_data);
            $display("  piece %0d/%0d x %h/%h y %h/%h w %h/%h h %h/%h", exp_q.piece,
                     out_data.piece, exp_q.quad_x, out_data.quad_x, exp_q.quad_y,
                     out_data.quad_y, exp_q.quad_w, out_data.quad_w, exp_q.quad_h,
                     out_data.quad_h);
            $display("  uv %h %h %h %h / %h %h %h %h flip %b/%b last %b/%b",
                     exp_q.uv_left, exp_q.uv_top, exp_q.uv_right, exp_q.uv_bottom,
                     out_data.uv_left, out_data.uv_top, out_data.uv_right,
                     out_data.uv_bottom, exp_q.flip_out, out_data.flip_out,
                     exp_q.last, out_data.last);
            fail_count++;
          end
        end
      end
    end
  end

  // Holds cfg_valid high; the caller drops it after the last write.
  task automatic write_border(input nsqg_pkg::nsqg_reg_t idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    borders[idx] = val;
  endtask

  task automatic set_borders(input logic [7:0] l, input logic [7:0] t,
                             input logic [7:0] r, input logic [7:0] b);
    start <= 1'b0;
    while (quad_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    write_border(nsqg_pkg::REG_LEFT, l);
    write_border(nsqg_pkg::REG_TOP, t);
    write_border(nsqg_pkg::REG_RIGHT, r);
    write_border(nsqg_pkg::REG_BOTTOM, b);
    cfg_valid <= 1'b0;
  endtask

  // Leaves start high after the beat; a following gap or the caller drops it.
  task automatic send_widget(input nsqg_pkg::nsqg_in_t w);
    int gap;
    gap = $urandom_range(0, 9);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_data <= w;
    do @(posedge clk); while (busy);
    predict_quads(w);
  endtask

  function automatic nsqg_pkg::nsqg_in_t rand_widget(input bit wide);
    nsqg_pkg::nsqg_in_t w;
    w.pos_x   = 24'($urandom);
    w.pos_y   = 24'($urandom);
    w.size_w  = 24'($urandom);
    w.size_h  = 24'($urandom);
    w.scale   = wide ? 16'($urandom) : 16'($urandom_range(0, 1023));
    w.atlas_x = 11'($urandom);
    w.atlas_y = 11'($urandom);
    w.atlas_w = 12'($urandom_range(3, 2048));
    w.atlas_h = 12'($urandom_range(3, 2048));
    w.flipped = 1'($urandom);
    if ($urandom_range(0, 4) == 0) w.atlas_w = 12'($urandom_range(3, 8));
    return w;
  endfunction

  typedef struct {
    logic [23:0] px, py, sw, sh;
    logic [15:0] sc;
    logic [10:0] ax, ay;
    logic [11:0] aw, ah;
    logic        fl;
  } widget_row_t;

  // Directed widgets: field extremes, tiny and full atlas rectangles,
  // screen wrap and UV saturation.
  widget_row_t widget_table[] = '{
    '{24'h000000, 24'h000000, 24'h001000, 24'h001000, 16'h0100, 11'd0, 11'd0,
      12'd3, 12'd3, 1'b0},
    '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 16'hFFFF, 11'd2047, 11'd2047,
      12'd2048, 12'd2048, 1'b1},
    '{24'h800000, 24'h800000, 24'h800000, 24'h800000, 16'h0000, 11'd0, 11'd0,
      12'd2048, 12'd2048, 1'b0},
    '{24'hFFFFFF, 24'h000100, 24'hFFF000, 24'h000200, 16'h8000, 11'd1024, 11'd5,
      12'd4, 12'd3, 1'b1},
    '{24'h123456, 24'hABCDEF, 24'h00FF00, 24'hFF00FF, 16'h0080, 11'd2045, 11'd1,
      12'd3, 12'd2048, 1'b0},
    '{24'h555555, 24'hAAAAAA, 24'h2AAAAA, 24'hD55555, 16'h5555, 11'd1365, 11'd682,
      12'd1365, 12'd2730 & 12'hFFF, 1'b1}
  };

  initial begin
    nsqg_pkg::nsqg_in_t w;
    logic [7:0] bset[6][4];
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    fail_count = 0;
    quiet_cycles = 0;
    foreach (borders[i]) borders[i] = '0;
    bset = '{'{8'd0, 8'd0, 8'd0, 8'd0}, '{8'd255, 8'd255, 8'd255, 8'd255},
             '{8'd1, 8'd0, 8'd0, 8'd0}, '{8'd0, 8'd7, 8'd0, 8'd200},
             '{8'd16, 8'd16, 8'd16, 8'd16}, '{8'd0, 8'd0, 8'd255, 8'd1}};
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Pass 0 keeps the reset borders (center quad only); later passes set new borders.
    for (int s = 0; s < 6; s++) begin
      if (s > 0) set_borders(bset[s][0], bset[s][1], bset[s][2], bset[s][3]);
      foreach (widget_table[i]) begin
        if (s > 1 && i > 2) continue;
        w.pos_x = widget_table[i].px;
        w.pos_y = widget_table[i].py;
        w.size_w = widget_table[i].sw;
        w.size_h = widget_table[i].sh;
        w.scale = widget_table[i].sc;
        w.atlas_x = widget_table[i].ax;
        w.atlas_y = widget_table[i].ay;
        w.atlas_w = widget_table[i].aw;
        w.atlas_h = widget_table[i].ah;
        w.flipped = widget_table[i].fl;
        send_widget(w);
      end
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 50 == 0)
        set_borders($urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom),
                    $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom),
                    $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom),
                    $urandom_range(0, 3) == 0 ? 8'd0 : 8'($urandom));
      send_widget(rand_widget($urandom_range(0, 3) == 0));
    end

    start <= 1'b0;
    while (quad_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
